@@ rtl/u16550_pkg.sv @@
// Package for the simplified 16550 UART register model.
// Holds the item structs, command and offset codes, and receive FIFO sizing.
// No dependencies.
package u16550_pkg;

  // Receive FIFO sizing
  localparam int unsigned RxDepth = 64;
  localparam int unsigned PtrW    = $clog2(RxDepth);
  localparam int unsigned CntW    = $clog2(RxDepth + 1);

  // Item commands
  typedef enum logic [1:0] {
    CmdRead  = 2'd0,
    CmdWrite = 2'd1,
    CmdRx    = 2'd2
  } cmd_e;

  // Register offsets in the eight-byte window
  localparam logic [2:0] OffData  = 3'd0;
  localparam logic [2:0] OffIer   = 3'd1;
  localparam logic [2:0] OffIir   = 3'd2;
  localparam logic [2:0] OffLcr   = 3'd3;
  localparam logic [2:0] OffMcr   = 3'd4;
  localparam logic [2:0] OffLsr   = 3'd5;
  localparam logic [2:0] OffMsr   = 3'd6;
  localparam logic [2:0] OffScr   = 3'd7;

  // Fixed values
  localparam logic [7:0] IirFixedBits = 8'hc0;
  localparam logic [7:0] IirNone      = 8'h01;
  localparam logic [7:0] IirRxData    = 8'h04;
  localparam logic [7:0] IirTxEmpty   = 8'h02;
  localparam logic [7:0] MsrFixed     = 8'hb0;
  localparam logic [7:0] LsrReset     = 8'h60;
  localparam logic [7:0] LsrTxBits    = 8'h60;
  localparam logic [7:0] McrReset     = 8'h08;
  localparam logic [7:0] EscapeChar   = 8'h01;
  localparam logic [7:0] ExitChar     = 8'h78;

  typedef struct packed {
    logic [1:0] command;
    logic [2:0] bus_offset;
    logic [7:0] write_data;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_line;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_dropped;
    logic       exit_request;
  } out_item_t;

  // Register file to FIFO requests
  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] push_data;
  } fifo_ctrl_t;

  // FIFO fill status
  typedef struct packed {
    logic empty;
    logic one_left;
    logic full;
  } fifo_stat_t;

endpackage

@@ rtl/u16550_rx_fifo.sv @@
// Receive FIFO: byte memory with head/tail pointers and a fill count.
// Read data is registered and only changes on a pop. Uses u16550_pkg.
module u16550_rx_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  u16550_pkg::fifo_ctrl_t ctrl_i,
  output u16550_pkg::fifo_stat_t stat_o,
  output logic [7:0]             rd_data_o
);
  import u16550_pkg::*;

  logic [7:0]      mem [RxDepth];
  logic [7:0]      rd_data_q;
  logic [PtrW-1:0] head_q, head_d;
  logic [PtrW-1:0] tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    ptr_next = (p == PtrW'(RxDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  // Report fill level
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.one_left = (count_q == CntW'(1));
  assign stat_o.full     = (count_q == CntW'(RxDepth));
  assign rd_data_o       = rd_data_q;

  // Advance pointers and count
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (en_i && ctrl_i.push) begin
      tail_d  = ptr_next(tail_q);
      count_d = count_q + CntW'(1);
    end else if (en_i && ctrl_i.pop) begin
      head_d  = ptr_next(head_q);
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Write at tail, read at head into the data register
  always_ff @(posedge clk_i) begin
    if (en_i && ctrl_i.push) begin
      mem[tail_q] <= ctrl_i.push_data;
    end
    if (en_i && ctrl_i.pop) begin
      rd_data_q <= mem[head_q];
    end
  end

endmodule

@@ rtl/u16550_regfile.sv @@
// UART register file: decodes one item against the register state,
// forms the result fields and FIFO requests. Uses u16550_pkg.
module u16550_regfile (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  u16550_pkg::in_item_t   item_i,
  input  u16550_pkg::fifo_stat_t stat_i,
  output u16550_pkg::fifo_ctrl_t ctrl_o,
  output u16550_pkg::out_item_t  result_o,
  output logic                   sel_fifo_o
);
  import u16550_pkg::*;

  logic [7:0] dll_q, dll_d;
  logic [7:0] dlm_q, dlm_d;
  logic [7:0] ier_q, ier_d;
  logic [7:0] lcr_q, lcr_d;
  logic [7:0] mcr_q, mcr_d;
  logic [7:0] scr_q, scr_d;
  logic [7:0] fcr_q, fcr_d;
  logic [7:0] iir_q, iir_d;
  logic [7:0] lsr_q, lsr_d;
  logic       esc_q, esc_d;
  logic       recompute;
  logic       dlab;

  function automatic logic [7:0] iir_calc(input logic [7:0] ier, input logic [7:0] lsr);
    logic [7:0] cause;
    cause = IirNone;
    if (ier[0] && lsr[0]) begin
      cause = IirRxData;
    end else if (ier[1] && lsr[6]) begin
      cause = IirTxEmpty;
    end
    iir_calc = cause | IirFixedBits;
  endfunction

  assign dlab = lcr_q[7];

  // Decode the item and form next state
  always_comb begin
    dll_d      = dll_q;
    dlm_d      = dlm_q;
    ier_d      = ier_q;
    lcr_d      = lcr_q;
    mcr_d      = mcr_q;
    scr_d      = scr_q;
    fcr_d      = fcr_q;
    lsr_d      = lsr_q;
    esc_d      = esc_q;
    recompute  = 1'b0;
    ctrl_o     = '0;
    result_o   = '0;
    sel_fifo_o = 1'b0;
    case (item_i.command)
      CmdRead: begin
        unique case (item_i.bus_offset)
          OffData: begin
            if (dlab) begin
              result_o.read_data = dll_q;
            end else begin
              if (!stat_i.empty) begin
                ctrl_o.pop = 1'b1;
                sel_fifo_o = 1'b1;
              end
              if (stat_i.empty || stat_i.one_left) begin
                lsr_d[0]  = 1'b0;
                recompute = 1'b1;
              end
            end
          end
          OffIer:  result_o.read_data = dlab ? dlm_q : ier_q;
          OffIir:  result_o.read_data = iir_q | IirFixedBits;
          OffLcr:  result_o.read_data = lcr_q;
          OffMcr:  result_o.read_data = mcr_q;
          OffLsr:  result_o.read_data = lsr_q;
          OffMsr:  result_o.read_data = MsrFixed;
          OffScr:  result_o.read_data = scr_q;
          default: result_o.read_data = '0;
        endcase
      end
      CmdWrite: begin
        unique case (item_i.bus_offset)
          OffData: begin
            if (dlab) begin
              dll_d = item_i.write_data;
            end else begin
              result_o.tx_valid = 1'b1;
              result_o.tx_byte  = item_i.write_data;
              lsr_d             = lsr_q | LsrTxBits;
              recompute         = 1'b1;
            end
          end
          OffIer: begin
            if (dlab) begin
              dlm_d = item_i.write_data;
            end else begin
              ier_d     = item_i.write_data;
              recompute = 1'b1;
            end
          end
          OffIir:  fcr_d = item_i.write_data;
          OffLcr:  lcr_d = item_i.write_data;
          OffMcr:  mcr_d = item_i.write_data;
          OffScr:  scr_d = item_i.write_data;
          default: ;
        endcase
      end
      CmdRx: begin
        recompute = 1'b1;
        if (stat_i.full) begin
          result_o.rx_dropped = 1'b1;
        end else if (esc_q && item_i.rx_byte == ExitChar) begin
          result_o.exit_request = 1'b1;
          esc_d                 = 1'b0;
        end else if (!esc_q && item_i.rx_byte == EscapeChar) begin
          esc_d = 1'b1;
        end else begin
          esc_d            = 1'b0;
          ctrl_o.push      = 1'b1;
          ctrl_o.push_data = item_i.rx_byte;
          lsr_d[0]         = 1'b1;
        end
      end
      default: ;
    endcase
    iir_d             = recompute ? iir_calc(ier_d, lsr_d) : iir_q;
    result_o.irq_line = (iir_d[3:0] != IirNone[3:0]);
  end

  // Hold register state, update when the item completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dll_q <= '0;
      dlm_q <= '0;
      ier_q <= '0;
      lcr_q <= '0;
      mcr_q <= McrReset;
      scr_q <= '0;
      fcr_q <= '0;
      iir_q <= IirNone;
      lsr_q <= LsrReset;
      esc_q <= 1'b0;
    end else if (en_i) begin
      dll_q <= dll_d;
      dlm_q <= dlm_d;
      ier_q <= ier_d;
      lcr_q <= lcr_d;
      mcr_q <= mcr_d;
      scr_q <= scr_d;
      fcr_q <= fcr_d;
      iir_q <= iir_d;
      lsr_q <= lsr_d;
      esc_q <= esc_d;
    end
  end

endmodule

@@ rtl/uart_16550_register_model_top.sv @@
// Top level of the simplified 16550 UART register model.
// Instantiates u16550_regfile and u16550_rx_fifo; uses u16550_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) carries one item:
//   a bus read, a bus write or a console byte. Output channel
//   (out_valid_o / out_stall_i / out_item_o) returns exactly one result
//   item per input item, in order.
//   The item is captured in an input register, decoded against the register
//   state in one pass, and its result is captured in the result register.
//   Throughput is one item per cycle while the output is not stalled; the
//   register file and the 64-entry receive FIFO (one write port at the
//   tail, one registered read port at the head) update once per item.
//   When the receiver stalls, the result register holds and the input
//   register holds; in_stall_o rises only when both are full and the
//   output is stalled, so one new item is still taken while a result waits.
//   Reset clears both valid flags, the FIFO pointers and the registers
//   to their documented values; FIFO contents are left undefined.
module uart_16550_register_model_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  u16550_pkg::in_item_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output u16550_pkg::out_item_t out_item_o
);
  import u16550_pkg::*;

  logic       in_valid_q;
  in_item_t   in_q;
  logic       out_valid_q;
  out_item_t  out_q;
  logic       sel_fifo_q;
  logic       advance;
  logic       in_take;
  logic       sel_fifo;
  out_item_t  result;
  fifo_ctrl_t fifo_ctrl;
  fifo_stat_t fifo_stat;
  logic [7:0] fifo_rd_data;

  // Move the held item into the result register when there is room
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  u16550_regfile u_regfile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance),
    .item_i     (in_q),
    .stat_i     (fifo_stat),
    .ctrl_o     (fifo_ctrl),
    .result_o   (result),
    .sel_fifo_o (sel_fifo)
  );

  u16550_rx_fifo u_rx_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .ctrl_i    (fifo_ctrl),
    .stat_o    (fifo_stat),
    .rd_data_o (fifo_rd_data)
  );

  // Input register valid and result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture payloads
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_item_i;
    end
    if (advance) begin
      out_q      <= result;
      sel_fifo_q <= sel_fifo;
    end
  end

  // Drive the result, taking receive data from the FIFO read register
  always_comb begin
    out_item_o = out_q;
    if (sel_fifo_q) begin
      out_item_o.read_data = fifo_rd_data;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
